[hw/rtl/sme_pkg.sv]
// Shared definitions for the stack machine executor: opcodes, status codes,
// write-back kinds and default sizing. No dependencies.
package sme_pkg;

	localparam int unsigned DEF_STACK_DEPTH = 16;
	localparam int unsigned NUM_REGS        = 3;
	localparam int unsigned DATA_W          = 32;

	typedef enum logic [3:0] {
		OP_PUSH  = 4'd0,
		OP_ADD   = 4'd1,
		OP_POP   = 4'd2,
		OP_SET   = 4'd3,
		OP_GET   = 4'd4,
		OP_MOVE  = 4'd5,
		OP_PRINT = 4'd6,
		OP_JUMP  = 4'd7,
		OP_HALT  = 4'd8
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_UNDER  = 3'd1,
		ST_OVER   = 3'd2,
		ST_BADREG = 3'd3,
		ST_HALTED = 3'd4
	} status_t;

	// What the second stage writes back into the stack memory
	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_DATA = 2'd1,
		WR_SUM  = 2'd2
	} wr_kind_t;

endpackage

[hw/rtl/sme_in_if.sv]
// Instruction request channel: valid/ready plus the decoded instruction fields.
// Depends on nothing.
interface sme_in_if;
	logic               valid;
	logic               ready;
	logic        [3:0]  func;
	logic signed [31:0] push_value;
	logic        [1:0]  reg_index;
	logic signed [31:0] set_value;

	modport source (output valid, func, push_value, reg_index, set_value, input ready);
	modport sink   (input valid, func, push_value, reg_index, set_value, output ready);
endinterface

[hw/rtl/sme_out_if.sv]
// Result request channel: valid/ready plus print flag, value and status.
// Depends on nothing.
interface sme_out_if;
	logic               valid;
	logic               ready;
	logic               print_valid;
	logic signed [31:0] print_value;
	logic        [2:0]  status;

	modport source (output valid, print_valid, print_value, status, input ready);
	modport sink   (input valid, print_valid, print_value, status, output ready);
endinterface

[hw/rtl/sme_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
module sme_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem_q[raddr0];
			rdata1 <= mem_q[raddr1];
		end
	end
endmodule

[hw/rtl/stack_machine_executor_core.sv]
// Stack machine executor top level: control, register file and pipeline.
// Depends on sme_pkg, sme_in_if, sme_out_if and sme_ram.
//
// Usage
//   instr  : one decoded instruction per request (func, push_value,
//            reg_index, set_value), taken when valid and ready are high.
//   result : exactly one result request per instruction, in order
//            (print_valid, print_value, status).
//   Path   : a result is offered on result once its instruction has passed
//            the stack memory read in the second stage and then the output
//            register; a stall on result can hold it in either.
//   Throughput: one instruction per cycle while results are drained; the
//            figure is set by the single write port of the stack memory,
//            which each instruction uses at most once in its second stage.
//   Reset : arst_n clears the stack count, the three registers, the halted
//            flag and the pipeline valids. The stack memory is not cleared;
//            only entries below the count are ever used.
//   Stall : when result is held off, the output register keeps its request,
//            the second stage holds with its read data, and instr.ready
//            drops only once that stage is also occupied.
module stack_machine_executor_core #(
	parameter int unsigned STACK_DEPTH = sme_pkg::DEF_STACK_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	sme_in_if.sink        instr,
	sme_out_if.source     result
);
	import sme_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	// Architectural control state
	logic [CW-1:0]     count_q;
	logic              halted_q;
	logic [DATA_W-1:0] regs_q [NUM_REGS];

	// Second stage: read data arrives from the stack memory here
	logic              valid_s1;
	wr_kind_t          wr_s1;
	logic [AW-1:0]     waddr_s1;
	logic [DATA_W-1:0] wdata_s1;
	logic              pop_s1;
	status_t           status_s1;
	logic              hit0_s1;
	logic              hit1_s1;
	logic [DATA_W-1:0] fwd_data_s1;

	// Output register
	logic              out_valid_q;
	logic              out_print_valid_q;
	logic [DATA_W-1:0] out_print_value_q;
	status_t           out_status_q;

	logic accept;
	logic s1_adv;

	// Decode at accept
	status_t           dec_status;
	logic [CW-1:0]     dec_count;
	wr_kind_t          dec_wr;
	logic [AW-1:0]     dec_waddr;
	logic [DATA_W-1:0] dec_wdata;
	logic              dec_pop;
	logic              dec_halt;
	logic              dec_reg_we;
	logic [DATA_W-1:0] reg_rd;
	logic [CW-1:0]     cnt_m1;
	logic [CW-1:0]     cnt_m2;
	logic              full;

	// Memory port signals
	logic              ram_we;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rd0;
	logic [DATA_W-1:0] ram_rd1;
	logic [DATA_W-1:0] rd0;
	logic [DATA_W-1:0] rd1;
	logic [DATA_W-1:0] sum;

	// Advance the second stage whenever the output register is free or emptying
	assign s1_adv       = valid_s1 && (!out_valid_q || result.ready);
	assign instr.ready  = !valid_s1 || s1_adv;
	assign accept       = instr.valid && instr.ready;

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign full   = (count_q == CW'(STACK_DEPTH));

	// Register read for get; index three never reaches a push
	always_comb begin
		unique case (instr.reg_index)
			2'd0:    reg_rd = regs_q[0];
			2'd1:    reg_rd = regs_q[1];
			2'd2:    reg_rd = regs_q[2];
			default: reg_rd = '0;
		endcase
	end

	// Decode the instruction against the current count and halted flag.
	// Faults leave every piece of state untouched.
	always_comb begin
		dec_status = ST_OK;
		dec_count  = count_q;
		dec_wr     = WR_NONE;
		dec_waddr  = count_q[AW-1:0];
		dec_wdata  = instr.push_value;
		dec_pop    = 1'b0;
		dec_halt   = halted_q;
		dec_reg_we = 1'b0;
		if (halted_q) begin
			dec_status = ST_HALTED;
		end else begin
			unique case (instr.func)
				OP_PUSH: begin
					if (full) begin
						dec_status = ST_OVER;
					end else begin
						dec_wr    = WR_DATA;
						dec_count = count_q + CW'(1);
					end
				end
				OP_ADD: begin
					if (count_q < CW'(2)) begin
						dec_status = ST_UNDER;
					end else begin
						// sum lands in the slot of the lower operand
						dec_wr    = WR_SUM;
						dec_waddr = cnt_m2[AW-1:0];
						dec_count = cnt_m1;
					end
				end
				OP_POP: begin
					if (count_q == '0) begin
						dec_status = ST_UNDER;
					end else begin
						dec_pop   = 1'b1;
						dec_count = cnt_m1;
					end
				end
				OP_SET: begin
					if (instr.reg_index == 2'd3) begin
						dec_status = ST_BADREG;
					end else begin
						dec_reg_we = 1'b1;
					end
				end
				OP_GET: begin
					// bad register takes precedence over a full stack
					if (instr.reg_index == 2'd3) begin
						dec_status = ST_BADREG;
					end else if (full) begin
						dec_status = ST_OVER;
					end else begin
						dec_wr    = WR_DATA;
						dec_wdata = reg_rd;
						dec_count = count_q + CW'(1);
					end
				end
				OP_HALT: begin
					dec_halt   = 1'b1;
					dec_status = ST_HALTED;
				end
				default: begin
					// move, print, jump and unused codes do nothing
				end
			endcase
		end
	end

	// Control state updates at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			halted_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (accept) begin
			count_q  <= dec_count;
			halted_q <= dec_halt;
			if (dec_reg_we) begin
				regs_q[instr.reg_index] <= instr.set_value;
			end
		end
	end

	// Second stage; forward its write when the same edge samples that entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_s1       <= dec_wr;
			waddr_s1    <= dec_waddr;
			wdata_s1    <= dec_wdata;
			pop_s1      <= dec_pop;
			status_s1   <= dec_status;
			hit0_s1     <= ram_we && (waddr_s1 == cnt_m1[AW-1:0]);
			hit1_s1     <= ram_we && (waddr_s1 == cnt_m2[AW-1:0]);
			fwd_data_s1 <= ram_wdata;
		end
	end

	assign rd0       = hit0_s1 ? fwd_data_s1 : ram_rd0;
	assign rd1       = hit1_s1 ? fwd_data_s1 : ram_rd1;
	assign sum       = rd0 + rd1;
	assign ram_we    = s1_adv && (wr_s1 != WR_NONE);
	assign ram_wdata = (wr_s1 == WR_SUM) ? sum : wdata_s1;

	sme_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (waddr_s1),
		.wdata  (ram_wdata),
		.re     (accept),
		.raddr0 (cnt_m1[AW-1:0]),
		.raddr1 (cnt_m2[AW-1:0]),
		.rdata0 (ram_rd0),
		.rdata1 (ram_rd1)
	);

	// Output register: load from the second stage, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_print_valid_q <= pop_s1;
			out_print_value_q <= pop_s1 ? rd0 : '0;
			out_status_q      <= status_s1;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.print_valid = out_print_valid_q;
	assign result.print_value = out_print_value_q;
	assign result.status      = out_status_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q && $stable(count_q))
		else $error("state moved after halt");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(waddr_s1) && $stable(wr_s1))
		else $error("second stage lost its instruction under stall");

	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_print_valid_q |-> out_status_q == ST_OK)
		else $error("printed value with fault status");

	a_no_accept_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !result.ready |-> !instr.ready)
		else $error("instruction taken while pipeline held");

endmodule

[tb/sv/tb_stack_machine_executor_core.sv]
// Self-checking testbench for stack_machine_executor_core: drives instruction
// requests, predicts every result with its own stack machine model and checks it.
// Depends on sme_pkg, sme_in_if, sme_out_if and the core itself.
module tb_stack_machine_executor_core;
	import sme_pkg::*;

	localparam int unsigned DEPTH          = DEF_STACK_DEPTH;
	localparam int unsigned HOLDOFF_CYCLES = 60;
	localparam int unsigned STUCK_LIMIT    = 2000;
	localparam int unsigned RANDOM_PER_PHASE = 560;

	// One instruction request as presented on the instr channel
	typedef struct packed {
		logic        [3:0]  func;
		logic signed [31:0] push_value;
		logic        [1:0]  reg_index;
		logic signed [31:0] set_value;
	} instr_t;

	// One result request as seen on the result channel
	typedef struct packed {
		logic               print_valid;
		logic signed [31:0] print_value;
		status_t            status;
	} outcome_t;

	// Tracks the machine state as the core should see it and keeps the
	// outcomes still owed by the core, oldest first.
	class stack_tracker;
		logic [31:0]  stack_mem [DEPTH];
		int unsigned  stack_count;
		logic [31:0]  gen_regs [NUM_REGS];
		bit           halted;
		outcome_t     outcome_q [$];
		int unsigned  mismatches;
		int unsigned  seen;

		function new();
			stack_count = 0;
			halted      = 1'b0;
			mismatches  = 0;
			seen        = 0;
			foreach (gen_regs[i])
				gen_regs[i] = '0;
		endfunction

		function automatic status_t push_word(logic [31:0] word);
			if (stack_count >= DEPTH)
				return ST_OVER;
			stack_mem[stack_count] = word;
			stack_count++;
			return ST_OK;
		endfunction

		// Advance the state by one accepted instruction and note its outcome
		function void take_instr(instr_t req);
			outcome_t    exp_out;
			logic [31:0] sum;
			exp_out = '{print_valid: 1'b0, print_value: '0, status: ST_OK};
			if (halted) begin
				exp_out.status = ST_HALTED;
			end else begin
				case (req.func)
					OP_PUSH: exp_out.status = push_word(req.push_value);
					OP_ADD: begin
						if (stack_count < 2) begin
							exp_out.status = ST_UNDER;
						end else begin
							sum = stack_mem[stack_count - 1] + stack_mem[stack_count - 2];
							stack_count--;
							stack_mem[stack_count - 1] = sum;
						end
					end
					OP_POP: begin
						if (stack_count == 0) begin
							exp_out.status = ST_UNDER;
						end else begin
							stack_count--;
							exp_out.print_value = stack_mem[stack_count];
							exp_out.print_valid = 1'b1;
						end
					end
					OP_SET: begin
						if (req.reg_index >= NUM_REGS)
							exp_out.status = ST_BADREG;
						else
							gen_regs[req.reg_index] = req.set_value;
					end
					OP_GET: begin
						if (req.reg_index >= NUM_REGS)
							exp_out.status = ST_BADREG;
						else
							exp_out.status = push_word(gen_regs[req.reg_index]);
					end
					OP_HALT: begin
						halted         = 1'b1;
						exp_out.status = ST_HALTED;
					end
					default: ;
				endcase
			end
			outcome_q.push_back(exp_out);
		endfunction

		// Compare one result with the oldest outstanding outcome
		function void match_outcome(outcome_t got);
			outcome_t exp_out;
			seen++;
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing outstanding", seen);
				return;
			end
			exp_out = outcome_q.pop_front();
			if (got.print_valid !== exp_out.print_valid ||
			    got.print_value !== exp_out.print_value ||
			    got.status !== exp_out.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected valid=%0b value=%h status=%0d, got valid=%0b value=%h status=%0d",
						seen, exp_out.print_valid, exp_out.print_value, exp_out.status,
						got.print_valid, got.print_value, got.status);
			end
		endfunction

		function int unsigned pending();
			return outcome_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sme_in_if  instr ();
	sme_out_if result ();

	stack_machine_executor_core #(
		.STACK_DEPTH(DEPTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr),
		.result (result)
	);

	stack_tracker tracker = new();

	int unsigned source_idle_pct = 0;
	int unsigned sink_stall_pct  = 0;
	bit          holdoff_req     = 1'b0;
	bit          grow_stack      = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side: stall at random, or hold off for a long stretch on request
	// so that the pipeline fills and instr.ready drops.
	initial begin
		int unsigned hold_cnt;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				result.ready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLDOFF_CYCLES; hold_cnt++)
					@(posedge clk);
			end
			result.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Check every result request at the edge that moves it
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			tracker.match_outcome('{print_valid: result.print_valid,
				print_value: result.print_value, status: status_t'(result.status)});
	end

	// Give up once nothing has moved on either channel for too long
	initial begin
		int unsigned stuck_cycles;
		stuck_cycles = 0;
		while (stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
			if ((instr.valid && instr.ready) || (result.valid && result.ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Offer one request, idling first at the current rate, and hold it until
	// the core takes it; the prediction advances only on acceptance.
	task automatic send_instr(instr_t req);
		while ($urandom_range(99) < source_idle_pct) begin
			instr.valid <= 1'b0;
			@(posedge clk);
		end
		instr.valid      <= 1'b1;
		instr.func       <= req.func;
		instr.push_value <= req.push_value;
		instr.reg_index  <= req.reg_index;
		instr.set_value  <= req.set_value;
		do
			@(posedge clk);
		while (!instr.ready);
		tracker.take_instr(req);
	endtask

	task automatic send_op(logic [3:0] f, logic [31:0] pv, logic [1:0] ri,
			logic [31:0] sv);
		send_instr('{func: f, push_value: pv, reg_index: ri, set_value: sv});
	endtask

	// Drop valid and wait until every outstanding result has come back
	task automatic wait_drained();
		instr.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// Data words lean on the extremes and small values now and then
	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
			3: return $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	// Build a random instruction; the mix leans on growing or draining the
	// stack so that both the full and the empty ends are hit often.
	function automatic instr_t pick_instr();
		instr_t      req;
		int unsigned roll;
		req.push_value = pick_word();
		req.set_value  = pick_word();
		req.reg_index  = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
		roll = $urandom_range(99);
		if (grow_stack) begin
			if (roll < 35)      req.func = OP_PUSH;
			else if (roll < 50) req.func = OP_GET;
			else if (roll < 62) req.func = OP_ADD;
			else if (roll < 74) req.func = OP_POP;
			else if (roll < 88) req.func = OP_SET;
			else                req.func = 4'($urandom_range(1) ? $urandom_range(5, 7)
			                                               : $urandom_range(9, 15));
		end else begin
			if (roll < 15)      req.func = OP_PUSH;
			else if (roll < 22) req.func = OP_GET;
			else if (roll < 47) req.func = OP_ADD;
			else if (roll < 77) req.func = OP_POP;
			else if (roll < 88) req.func = OP_SET;
			else                req.func = 4'($urandom_range(1) ? $urandom_range(5, 7)
			                                               : $urandom_range(9, 15));
		end
		return req;
	endfunction

	task automatic run_random(int unsigned count);
		int unsigned n;
		for (n = 0; n < count; n++) begin
			// turn round at either end of the stack, and now and then at random
			if (tracker.stack_count == DEPTH && $urandom_range(3) == 0)
				grow_stack = 1'b0;
			else if (tracker.stack_count == 0 && $urandom_range(3) == 0)
				grow_stack = 1'b1;
			else if ($urandom_range(49) == 0)
				grow_stack = !grow_stack;
			send_instr(pick_instr());
		end
	endtask

	initial begin
		int unsigned f;
		arst_n           = 1'b0;
		instr.valid      <= 1'b0;
		instr.func       <= OP_PUSH;
		instr.push_value <= '0;
		instr.reg_index  <= '0;
		instr.set_value  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender idles lightly, receiver stalls heavily
		source_idle_pct = 33;
		sink_stall_pct  = 80;

		// Directed: underflow on an empty stack, wrap of the sum, bad register
		// on set and get, every register, move, print, jump and two unused codes.
		send_op(OP_POP,  32'h0, 2'd0, 32'h0);
		send_op(OP_ADD,  32'h0, 2'd0, 32'h0);
		send_op(OP_PUSH, 32'h7fff_ffff, 2'd0, 32'h0);
		send_op(OP_ADD,  32'h0, 2'd0, 32'h0);
		send_op(OP_PUSH, 32'h0000_0001, 2'd0, 32'h0);
		send_op(OP_ADD,  32'h0, 2'd0, 32'h0);
		send_op(OP_POP,  32'h0, 2'd0, 32'h0);
		send_op(OP_SET,  32'h0, 2'd0, 32'hffff_ffff);
		send_op(OP_SET,  32'h0, 2'd1, 32'h8000_0000);
		send_op(OP_SET,  32'h0, 2'd2, 32'h7fff_ffff);
		send_op(OP_SET,  32'h0, 2'd3, 32'h1234_5678);
		send_op(OP_GET,  32'h0, 2'd3, 32'h0);
		send_op(OP_GET,  32'h0, 2'd0, 32'h0);
		send_op(OP_GET,  32'h0, 2'd1, 32'h0);
		send_op(OP_GET,  32'h0, 2'd2, 32'h0);
		send_op(OP_PUSH, 32'h8000_0000, 2'd0, 32'h0);
		send_op(OP_PUSH, 32'hffff_ffff, 2'd0, 32'h0);
		send_op(OP_MOVE, 32'h0, 2'd0, 32'h0);
		send_op(OP_PRINT, 32'h0, 2'd0, 32'h0);
		send_op(OP_JUMP, 32'h0, 2'd0, 32'h0);
		send_op(4'd9,    32'h0, 2'd0, 32'h0);
		send_op(4'd15,   32'hffff_ffff, 2'd3, 32'hffff_ffff);
		send_op(OP_POP,  32'h0, 2'd0, 32'h0);

		run_random(RANDOM_PER_PHASE);

		// Phase two: the other way round
		source_idle_pct = 80;
		sink_stall_pct  = 33;
		run_random(RANDOM_PER_PHASE);

		// Pause the sender until the core has returned everything
		wait_drained();

		// Phase three: no idling, opened by a long hold-off on the result side
		// while requests keep coming, so that the core backs up
		source_idle_pct = 0;
		sink_stall_pct  = 0;
		holdoff_req     = 1'b1;
		run_random(RANDOM_PER_PHASE);

		// Halt, then every opcode once more: all must report halted
		send_op(OP_HALT, pick_word(), 2'($urandom_range(3)), pick_word());
		for (f = 0; f < 16; f++)
			send_op(4'(f), pick_word(), 2'($urandom_range(3)), pick_word());

		wait_drained();
		repeat (6) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
